// ===== src/cbsf_pkg.sv =====
// Shared types and constants for the cubic Bezier spline flattener.
`timescale 1ns / 1ps

package cbsf_pkg;

    // Width and reset value of the points-per-segment register
    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd16;

    // Which of the six de Casteljau interpolations the shared unit runs
    typedef enum logic [2:0] {
        LERP_A = 3'd0,   // P0 -> P1
        LERP_B = 3'd1,   // P1 -> P2
        LERP_C = 3'd2,   // P2 -> P3
        LERP_D = 3'd3,   // L1 -> L2
        LERP_E = 3'd4,   // L2 -> L3
        LERP_F = 3'd5    // L4 -> L5, the point on the curve
    } lerp_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load_knot;
        logic      div_step;
        logic      t_step;
        logic      mul;
        logic      add;
        lerp_sel_t sel;
        logic      emit;
    } cbsf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic curve;       // accepted knot closes a curve segment
        logic last_point;  // current point is j = n
        logic out_free;    // output register can take a new segment
    } cbsf_sts_t;

endpackage

// ===== src/cbsf_ctrl.sv =====
// Sequencing state machine of the cubic Bezier spline flattener.
`timescale 1ns / 1ps

module cbsf_ctrl #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               knot_valid,
    output logic               knot_stall,
    input  cbsf_pkg::cbsf_sts_t sts,
    output cbsf_pkg::cbsf_cmd_t cmd
);
    import cbsf_pkg::*;

    localparam int CNT_W = $clog2(T_FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(T_FRAC_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_TSTEP = 6'b000100,
        S_MUL   = 6'b001000,
        S_ADD   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    lerp_sel_t        sel_reg, sel_next;

    assign knot_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.sel      = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (knot_valid)
                begin
                    cmd.load_knot = 1'b1;
                    div_cnt_next  = '0;
                    if (sts.curve)
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_TSTEP;
            end
            S_TSTEP:
            begin
                cmd.t_step = 1'b1;
                sel_next   = LERP_A;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                unique case (sel_reg)
                    LERP_A:  sel_next = LERP_B;
                    LERP_B:  sel_next = LERP_C;
                    LERP_C:  sel_next = LERP_D;
                    LERP_D:  sel_next = LERP_E;
                    LERP_E:  sel_next = LERP_F;
                    default: sel_next = LERP_A;
                endcase
                state_next = (sel_reg == LERP_F) ? S_EMIT : S_MUL;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_point ? S_IDLE : S_TSTEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            sel_reg     <= LERP_A;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            sel_reg     <= sel_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_final_lerp_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && sel_reg == LERP_F) |=> state_reg == S_EMIT)
        else $error("final interpolation not followed by emit");

    a_last_point_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && sts.out_free && sts.last_point) |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after last segment");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> div_cnt_reg <= DIV_LAST)
        else $error("divider step count overran");

    a_no_curve_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && knot_valid && !sts.curve) |=> state_reg == S_IDLE)
        else $error("knot without a curve segment left idle");
`endif

endmodule

// ===== src/cbsf_dp.sv =====
// Datapath of the cubic Bezier spline flattener: knot store, t divider, shared lerp, output.
`timescale 1ns / 1ps

module cbsf_dp #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16,
    parameter int MAX_STEPS   = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [cbsf_pkg::CFG_WIDTH-1:0]        points_per_segment,
    input  logic signed [COORD_WIDTH-1:0]         pos_x,
    input  logic signed [COORD_WIDTH-1:0]         pos_y,
    input  logic signed [COORD_WIDTH-1:0]         handle_in_x,
    input  logic signed [COORD_WIDTH-1:0]         handle_in_y,
    input  logic signed [COORD_WIDTH-1:0]         handle_out_x,
    input  logic signed [COORD_WIDTH-1:0]         handle_out_y,
    input  logic                                  new_spline,
    input  cbsf_pkg::cbsf_cmd_t                   cmd,
    output cbsf_pkg::cbsf_sts_t                   sts,
    output logic                                  seg_valid,
    input  logic                                  seg_stall,
    output logic signed [COORD_WIDTH-1:0]         seg_start_x,
    output logic signed [COORD_WIDTH-1:0]         seg_start_y,
    output logic signed [COORD_WIDTH-1:0]         seg_end_x,
    output logic signed [COORD_WIDTH-1:0]         seg_end_y,
    output logic                                  last_segment
);
    import cbsf_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int PW  = CW + F + 3;
    localparam int J_W = $clog2(MAX_STEPS + 1);
    localparam logic [CFG_WIDTH-1:0] MAX_N = CFG_WIDTH'(MAX_STEPS);
    localparam logic [CFG_WIDTH-1:0] MIN_N = CFG_WIDTH'(1);
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    // Previous knot
    logic signed [CW-1:0] prev_pos_reg  [2];
    logic signed [CW-1:0] prev_hout_reg [2];
    logic                 have_prev_reg;

    // Control points and intermediate points, index 0 is x, 1 is y
    logic signed [CW-1:0] p0_reg [2];
    logic signed [CW-1:0] p1_reg [2];
    logic signed [CW-1:0] p2_reg [2];
    logic signed [CW-1:0] p3_reg [2];
    logic signed [CW-1:0] l1_reg [2];
    logic signed [CW-1:0] l2_reg [2];
    logic signed [CW-1:0] l3_reg [2];
    logic signed [CW-1:0] l4_reg [2];
    logic signed [CW-1:0] l5_reg [2];
    logic signed [CW-1:0] end_reg [2];
    logic signed [CW-1:0] start_reg [2];

    // Lerp unit
    logic signed [CW-1:0] lerp_a   [2];
    logic signed [CW-1:0] lerp_b   [2];
    logic signed [CW:0]   lerp_diff [2];
    logic signed [PW-1:0] prod_next [2];
    logic signed [PW-1:0] prod_reg  [2];
    logic signed [CW-1:0] a_hold_reg [2];
    logic signed [CW-1:0] lerp_res  [2];
    logic signed [F+1:0]  t_signed;

    // Segment count, divider and t accumulator
    logic [CFG_WIDTH-1:0] n_eff;
    logic [CFG_WIDTH-1:0] n_reg;
    logic [F:0]           div_qd_reg;
    logic [CFG_WIDTH-1:0] div_rem_reg;
    logic [CFG_WIDTH:0]   rem_sh;
    logic                 rem_ge;
    logic [CFG_WIDTH-1:0] rem_next;
    logic [F:0]           t_q_reg;
    logic [CFG_WIDTH-1:0] t_r_reg;
    logic [CFG_WIDTH:0]   r_sum;
    logic                 r_wrap;
    logic [J_W-1:0]       j_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [CW-1:0] out_start_reg [2];
    logic signed [CW-1:0] out_end_reg   [2];
    logic                 out_last_reg;

    // Clamp n into 1..MAX_STEPS
    always_comb
    begin
        priority if (points_per_segment == '0)
            n_eff = MIN_N;
        else if (points_per_segment > MAX_N)
            n_eff = MAX_N;
        else
            n_eff = points_per_segment;
    end

    assign rem_sh   = {div_rem_reg, div_qd_reg[F]};
    assign rem_ge   = (rem_sh >= {1'b0, n_reg});
    assign rem_next = rem_ge ? CFG_WIDTH'(rem_sh - {1'b0, n_reg}) : rem_sh[CFG_WIDTH-1:0];

    assign r_sum  = {1'b0, t_r_reg} + {1'b0, div_rem_reg};
    assign r_wrap = (r_sum >= {1'b0, n_reg});

    assign t_signed = $signed({1'b0, t_q_reg});

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            unique case (cmd.sel)
                LERP_A:
                begin
                    lerp_a[a] = p0_reg[a];
                    lerp_b[a] = p1_reg[a];
                end
                LERP_B:
                begin
                    lerp_a[a] = p1_reg[a];
                    lerp_b[a] = p2_reg[a];
                end
                LERP_C:
                begin
                    lerp_a[a] = p2_reg[a];
                    lerp_b[a] = p3_reg[a];
                end
                LERP_D:
                begin
                    lerp_a[a] = l1_reg[a];
                    lerp_b[a] = l2_reg[a];
                end
                LERP_E:
                begin
                    lerp_a[a] = l2_reg[a];
                    lerp_b[a] = l3_reg[a];
                end
                LERP_F:
                begin
                    lerp_a[a] = l4_reg[a];
                    lerp_b[a] = l5_reg[a];
                end
                default:
                begin
                    lerp_a[a] = p0_reg[a];
                    lerp_b[a] = p1_reg[a];
                end
            endcase
            lerp_diff[a] = $signed({lerp_b[a][CW-1], lerp_b[a]})
                         - $signed({lerp_a[a][CW-1], lerp_a[a]});
            prod_next[a] = PW'(lerp_diff[a]) * PW'(t_signed);
            // floor shift of the product, then add; the sum stays in range
            lerp_res[a]  = a_hold_reg[a] + $signed(prod_reg[a][F +: CW]);
        end
    end

    assign sts.curve      = have_prev_reg && !new_spline;
    assign sts.last_point = (CFG_WIDTH'(j_reg) == n_reg);
    assign sts.out_free   = !out_valid_reg || !seg_stall;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= MIN_N;
            div_rem_reg   <= '0;
            div_qd_reg    <= '0;
            t_q_reg       <= '0;
            t_r_reg       <= '0;
            j_reg         <= '0;
        end
        else
        begin
            if (cmd.load_knot)
            begin
                have_prev_reg <= 1'b1;
                n_reg         <= n_eff;
                div_rem_reg   <= '0;
                div_qd_reg    <= T_ONE;
                t_q_reg       <= '0;
                t_r_reg       <= '0;
                j_reg         <= '0;
            end
            if (cmd.div_step)
            begin
                div_rem_reg <= rem_next;
                div_qd_reg  <= {div_qd_reg[F-1:0], rem_ge};
            end
            if (cmd.t_step)
            begin
                // t += 2^F / n, carrying the remainder
                t_q_reg <= t_q_reg + div_qd_reg + {{F{1'b0}}, r_wrap};
                t_r_reg <= r_wrap ? CFG_WIDTH'(r_sum - {1'b0, n_reg}) : r_sum[CFG_WIDTH-1:0];
                j_reg   <= j_reg + J_W'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!seg_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_knot)
        begin
            p0_reg[0]        <= prev_pos_reg[0];
            p0_reg[1]        <= prev_pos_reg[1];
            p1_reg[0]        <= prev_hout_reg[0];
            p1_reg[1]        <= prev_hout_reg[1];
            p2_reg[0]        <= handle_in_x;
            p2_reg[1]        <= handle_in_y;
            p3_reg[0]        <= pos_x;
            p3_reg[1]        <= pos_y;
            start_reg[0]     <= prev_pos_reg[0];
            start_reg[1]     <= prev_pos_reg[1];
            prev_pos_reg[0]  <= pos_x;
            prev_pos_reg[1]  <= pos_y;
            prev_hout_reg[0] <= handle_out_x;
            prev_hout_reg[1] <= handle_out_y;
        end
        for (int a = 0; a < 2; a++)
        begin
            if (cmd.mul)
            begin
                prod_reg[a]   <= prod_next[a];
                a_hold_reg[a] <= lerp_a[a];
            end
            if (cmd.add)
            begin
                unique case (cmd.sel)
                    LERP_A:  l1_reg[a]  <= lerp_res[a];
                    LERP_B:  l2_reg[a]  <= lerp_res[a];
                    LERP_C:  l3_reg[a]  <= lerp_res[a];
                    LERP_D:  l4_reg[a]  <= lerp_res[a];
                    LERP_E:  l5_reg[a]  <= lerp_res[a];
                    LERP_F:  end_reg[a] <= lerp_res[a];
                    default: end_reg[a] <= lerp_res[a];
                endcase
            end
            if (cmd.emit)
            begin
                out_start_reg[a] <= start_reg[a];
                out_end_reg[a]   <= end_reg[a];
                start_reg[a]     <= end_reg[a];
            end
        end
        if (cmd.emit)
            out_last_reg <= sts.last_point;
    end

    assign seg_valid    = out_valid_reg;
    assign seg_start_x  = out_start_reg[0];
    assign seg_start_y  = out_start_reg[1];
    assign seg_end_x    = out_end_reg[0];
    assign seg_end_y    = out_end_reg[1];
    assign last_segment = out_last_reg;

`ifndef NO_ASSERTIONS
    a_t_ends_at_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_point) |-> t_q_reg == T_ONE)
        else $error("t did not reach one on the last segment");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_rem_reg < n_reg)
        else $error("divider remainder not below segment count");

    a_t_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        t_r_reg < n_reg)
        else $error("t accumulator remainder not below segment count");
`endif

endmodule

// ===== src/cubic_bezier_spline_flattener.sv =====
// Top level of the cubic Bezier spline flattener: config register, controller, datapath.
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------------
// knot in  | knot_valid / knot_stall | pos_x/y, handle_in_x/y, handle_out_x/y,
//          |                         | new_spline
// seg out  | seg_valid / seg_stall   | seg_start_x/y, seg_end_x/y, last_segment
// config   | cfg_valid / cfg_ready   | cfg_data (points_per_segment)
//
// A knot that closes no curve segment (first knot, or new_spline set) is only
// stored. A knot that closes a segment runs the serial divide of 2^T_FRAC_BITS
// by n, then per point one t update, six multiply/add passes through the shared
// two-axis lerp unit and one emit, with n = 1..MAX_STEPS.
// The output register holds one segment; a stalled output holds the sequencer
// in its emit step, and the next knot is taken while the last segment waits.
// Reset clears the previous-knot flag and sets points_per_segment to 16.

module cubic_bezier_spline_flattener #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16,
    parameter int MAX_STEPS   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // knot channel
    input  logic                           knot_valid,
    output logic                           knot_stall,
    input  logic signed [COORD_WIDTH-1:0]  pos_x,
    input  logic signed [COORD_WIDTH-1:0]  pos_y,
    input  logic signed [COORD_WIDTH-1:0]  handle_in_x,
    input  logic signed [COORD_WIDTH-1:0]  handle_in_y,
    input  logic signed [COORD_WIDTH-1:0]  handle_out_x,
    input  logic signed [COORD_WIDTH-1:0]  handle_out_y,
    input  logic                           new_spline,
    // line segment channel
    output logic                           seg_valid,
    input  logic                           seg_stall,
    output logic signed [COORD_WIDTH-1:0]  seg_start_x,
    output logic signed [COORD_WIDTH-1:0]  seg_start_y,
    output logic signed [COORD_WIDTH-1:0]  seg_end_x,
    output logic signed [COORD_WIDTH-1:0]  seg_end_y,
    output logic                           last_segment,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbsf_pkg::CFG_WIDTH-1:0] cfg_data
);
    import cbsf_pkg::*;

    logic [CFG_WIDTH-1:0] points_per_segment_reg;
    cbsf_cmd_t            cmd;
    cbsf_sts_t            sts;

    // Config writes must land only while idle; the block does not enforce it and takes every transfer at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            points_per_segment_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
            points_per_segment_reg <= cfg_data;
    end

    cbsf_ctrl #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .knot_valid (knot_valid),
        .knot_stall (knot_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    cbsf_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .points_per_segment (points_per_segment_reg),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .handle_in_x        (handle_in_x),
        .handle_in_y        (handle_in_y),
        .handle_out_x       (handle_out_x),
        .handle_out_y       (handle_out_y),
        .new_spline         (new_spline),
        .cmd                (cmd),
        .sts                (sts),
        .seg_valid          (seg_valid),
        .seg_stall          (seg_stall),
        .seg_start_x        (seg_start_x),
        .seg_start_y        (seg_start_y),
        .seg_end_x          (seg_end_x),
        .seg_end_y          (seg_end_y),
        .last_segment       (last_segment)
    );

endmodule
